### hdl/epc_pkg.sv
// Shared types, constants and the month table of the epoch/date converter.
// Used by epc_d2e, epc_e2d and epoch_date_converter.
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

    // Datapath register stages; the output register in the top level adds one more.
    localparam int DP_STAGES  = 6;
    localparam int NUM_STAGES = DP_STAGES + 1;

    typedef logic [DP_STAGES-1:0] dp_en_t;

    // Action codes
    localparam logic ACT_TO_EPOCH = 1'b0;
    localparam logic ACT_TO_DATE  = 1'b1;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_OCT_IDX = 4'd10;

    // Day counts since 1970-01-01 of March 1st, 1999 and 2000
    localparam logic [16:0] DAYS_1999_MAR = 17'd10651;
    localparam logic [16:0] DAYS_2000_MAR = 17'd11017;

    localparam logic [31:0] SECS_PER_DAY = 32'd86400;

    // Era bounds, with the day count shifted to 0000-03-01
    localparam logic [19:0] DAY_SHIFT     = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [7:0]  ERA4_YEAR_ADJ = 8'd112;

    // Reciprocals for exact constant division over the value ranges in use.
    // epoch / 86400 = (epoch >> 7) / 675
    localparam int          DAY_RSH    = 35;
    localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_RSH) + 64'd674) / 64'd675);
    localparam int          Q1460_RSH  = 29;
    localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << Q1460_RSH) + 64'd1459) / 64'd1460);
    localparam int          Q365_RSH   = 27;
    localparam logic [18:0] RECIP_365  = 19'(((64'd1 << Q365_RSH) + 64'd364) / 64'd365);
    localparam int          Q153_RSH   = 19;
    localparam logic [11:0] RECIP_153  = 12'(((64'd1 << Q153_RSH) + 64'd152) / 64'd153);

    // Days from March 1st to the start of a March-based month: (153 * m + 2) / 5
    function automatic logic [8:0] month_days_before(input logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            4'd12:   days = 9'd367;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

### hdl/epc_d2e.sv
// Date and time to epoch seconds datapath: three working stages, three delay stages.
// Depends on epc_pkg for the month table and calendar constants.
`timescale 1ns / 1ps
`default_nettype none

module epc_d2e (
    input  wire                  clk,
    input  wire epc_pkg::dp_en_t stage_en,
    input  wire [7:0]            year_offset,
    input  wire [3:0]            month,
    input  wire [4:0]            day,
    input  wire [4:0]            hour,
    input  wire [5:0]            minute,
    input  wire [5:0]            second,
    output logic [31:0]          epoch_sec
);
    import epc_pkg::*;

    logic        mle2;
    logic [3:0]  mshift;
    logic [7:0]  yprev;
    logic [1:0]  ycent;
    logic [16:0] ydays;
    logic [16:0] tod;
    logic [9:0]  dsum;
    logic        wrap;

    logic [16:0] ydays_s1_reg;
    logic        wrap_s1_reg;
    logic [9:0]  dsum_s1_reg;
    logic [16:0] tod_s1_reg;

    logic [16:0] days;
    logic [16:0] days_s2_reg;
    logic [16:0] tod_s2_reg;

    logic [31:0] secs;
    logic [31:0] secs_pipe_reg [2:DP_STAGES-1];

    // Stage 1: March-based year and month, day of year, time of day
    always_comb
    begin
        mle2   = (month <= MONTH_FEB);
        mshift = mle2 ? (month + 4'd9) : (month - 4'd3);
        yprev  = year_offset - {7'd0, mle2};
        ycent  = (yprev >= 8'd200) ? 2'd2 : ((yprev >= 8'd100) ? 2'd1 : 2'd0);
        ydays  = 17'(yprev) * 17'd365 + 17'(yprev[7:2]) - 17'(ycent);
        tod    = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
        dsum   = 10'(month_days_before(mshift)) + 10'(day);
        // January and February of 2000 fall in the March-based year 1999
        wrap   = (year_offset == 8'd0) && mle2;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ydays_s1_reg <= ydays;
            wrap_s1_reg  <= wrap;
            dsum_s1_reg  <= dsum;
            tod_s1_reg   <= tod;
        end
    end

    // Stage 2: days since 1970-01-01
    always_comb
    begin
        days = (wrap_s1_reg ? DAYS_1999_MAR : (DAYS_2000_MAR + ydays_s1_reg))
             + 17'(dsum_s1_reg) - 17'd1;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            days_s2_reg <= days;
            tod_s2_reg  <= tod_s1_reg;
        end
    end

    // Stage 3: seconds, modulo 2^32
    assign secs = 32'(days_s2_reg) * SECS_PER_DAY + 32'(tod_s2_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            secs_pipe_reg[2] <= secs;
        end
        for (int k = 3; k < DP_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                secs_pipe_reg[k] <= secs_pipe_reg[k-1];
            end
        end
    end

    assign epoch_sec = secs_pipe_reg[DP_STAGES-1];

endmodule

`default_nettype wire

### hdl/epc_e2d.sv
// Epoch seconds to calendar date datapath: six register stages and the final
// day/month/year step. Depends on epc_pkg for reciprocals and the month table.
`timescale 1ns / 1ps
`default_nettype none

module epc_e2d (
    input  wire                  clk,
    input  wire epc_pkg::dp_en_t stage_en,
    input  wire [31:0]           epoch_in,
    output logic [7:0]           year_off,
    output logic [3:0]           mon,
    output logic [4:0]           mday
);
    import epc_pkg::*;

    logic [50:0] day_prod;
    logic [15:0] z_s1_reg;

    logic [19:0] zz;
    logic        era5;
    logic [17:0] doe;
    logic [17:0] doe_s2_reg;
    logic        era5_s2_reg;

    logic [36:0] q1460_prod;
    logic [6:0]  q1460;
    logic [2:0]  q36524;
    logic        q146096;
    logic [17:0] tval;
    logic [17:0] t_s3_reg;
    logic [17:0] doe_s3_reg;
    logic        era5_s3_reg;

    logic [36:0] q365_prod;
    logic [8:0]  yoe_s4_reg;
    logic [17:0] doe_s4_reg;
    logic        era5_s4_reg;

    logic [1:0]  ycent;
    logic [17:0] ydays;
    logic [8:0]  doy;
    logic [8:0]  doy_s5_reg;
    logic [8:0]  yoe_s5_reg;
    logic        era5_s5_reg;

    logic [10:0] mp_num;
    logic [22:0] mp_prod;
    logic [3:0]  mp_s6_reg;
    logic [8:0]  doy_s6_reg;
    logic [8:0]  yoe_s6_reg;
    logic        era5_s6_reg;

    logic [8:0]  dd;

    // Stage 1: day count = epoch / 86400
    assign day_prod = 51'(epoch_in[31:7]) * 51'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            z_s1_reg <= day_prod[DAY_RSH +: 16];
        end
    end

    // Stage 2: era and day of era
    always_comb
    begin
        zz   = 20'(z_s1_reg) + DAY_SHIFT;
        era5 = (zz >= ERA5_START);
        doe  = 18'(zz - (era5 ? ERA5_START : ERA4_START));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            doe_s2_reg  <= doe;
            era5_s2_reg <= era5;
        end
    end

    // Stage 3: remove leap days from the day of era
    always_comb
    begin
        q1460_prod = 37'(doe_s2_reg) * 37'(RECIP_1460);
        q1460      = q1460_prod[Q1460_RSH +: 7];
        q36524     = 3'(doe_s2_reg >= 18'd36524) + 3'(doe_s2_reg >= 18'd73048)
                   + 3'(doe_s2_reg >= 18'd109572) + 3'(doe_s2_reg >= 18'd146096);
        q146096    = (doe_s2_reg == 18'd146096);
        tval       = doe_s2_reg - 18'(q1460) + 18'(q36524) - 18'(q146096);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            t_s3_reg    <= tval;
            doe_s3_reg  <= doe_s2_reg;
            era5_s3_reg <= era5_s2_reg;
        end
    end

    // Stage 4: year of era
    assign q365_prod = 37'(t_s3_reg) * 37'(RECIP_365);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            yoe_s4_reg  <= q365_prod[Q365_RSH +: 9];
            doe_s4_reg  <= doe_s3_reg;
            era5_s4_reg <= era5_s3_reg;
        end
    end

    // Stage 5: day of March-based year
    always_comb
    begin
        ycent = (yoe_s4_reg >= 9'd300) ? 2'd3 :
                (yoe_s4_reg >= 9'd200) ? 2'd2 :
                (yoe_s4_reg >= 9'd100) ? 2'd1 : 2'd0;
        ydays = 18'(yoe_s4_reg) * 18'd365 + 18'(yoe_s4_reg[8:2]) - 18'(ycent);
        doy   = 9'(doe_s4_reg - ydays);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            doy_s5_reg  <= doy;
            yoe_s5_reg  <= yoe_s4_reg;
            era5_s5_reg <= era5_s4_reg;
        end
    end

    // Stage 6: March-based month = (5 * doy + 2) / 153
    always_comb
    begin
        mp_num  = 11'(doy_s5_reg) * 11'd5 + 11'd2;
        mp_prod = 23'(mp_num) * 23'(RECIP_153);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            mp_s6_reg   <= mp_prod[Q153_RSH +: 4];
            doy_s6_reg  <= doy_s5_reg;
            yoe_s6_reg  <= yoe_s5_reg;
            era5_s6_reg <= era5_s5_reg;
        end
    end

    // Final step, registered by the top level
    always_comb
    begin
        dd       = doy_s6_reg - month_days_before(mp_s6_reg) + 9'd1;
        mday     = dd[4:0];
        mon      = (mp_s6_reg < MONTH_OCT_IDX) ? (mp_s6_reg + 4'd3) : (mp_s6_reg - 4'd9);
        // Era 4 years sit 400 below era 5, i.e. +112 modulo 256
        year_off = yoe_s6_reg[7:0] + (era5_s6_reg ? 8'd0 : ERA4_YEAR_ADJ)
                 + {7'd0, (mon <= MONTH_FEB)};
    end

endmodule

`default_nettype wire

### hdl/epoch_date_converter.sv
// An input transfer reaches out_valid through the datapath stages and the output register.
// Throughput: one transfer per cycle while out_stall is low; stall ripples back through the seven stage
// valid bits, so a bubble in any stage is filled while the output is held.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
// Top level of the epoch/date converter; uses epc_pkg, epc_d2e and epc_e2d.
`timescale 1ns / 1ps
`default_nettype none

module epoch_date_converter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         action,
    input  wire [7:0]   year_offset,
    input  wire [3:0]   month,
    input  wire [4:0]   day,
    input  wire [4:0]   hour,
    input  wire [5:0]   minute,
    input  wire [5:0]   second,
    input  wire [31:0]  epoch_in,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] epoch_out,
    output logic [7:0]  out_year_offset,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day
);
    import epc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] act_reg;
    logic [NUM_STAGES-1:0] stage_en;

    logic [31:0] d2e_secs;
    logic [7:0]  e2d_year;
    logic [3:0]  e2d_month;
    logic [4:0]  e2d_day;

    logic [31:0] epoch_out_reg;
    logic [7:0]  year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;

    // A stage loads when it is empty or when the stage after it loads
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_stall = !stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            act_reg[0] <= action;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                act_reg[k] <= act_reg[k-1];
            end
        end
    end

    epc_d2e u_d2e (
        .clk         (clk),
        .stage_en    (stage_en[DP_STAGES-1:0]),
        .year_offset (year_offset),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .epoch_sec   (d2e_secs)
    );

    epc_e2d u_e2d (
        .clk      (clk),
        .stage_en (stage_en[DP_STAGES-1:0]),
        .epoch_in (epoch_in),
        .year_off (e2d_year),
        .mon      (e2d_month),
        .mday     (e2d_day)
    );

    // Output register: select by action, zero the fields the action does not produce
    always_ff @(posedge clk)
    begin
        if (stage_en[NUM_STAGES-1])
        begin
            if (act_reg[NUM_STAGES-2] == ACT_TO_DATE)
            begin
                epoch_out_reg <= 32'd0;
                year_out_reg  <= e2d_year;
                month_out_reg <= e2d_month;
                day_out_reg   <= e2d_day;
            end
            else
            begin
                epoch_out_reg <= d2e_secs;
                year_out_reg  <= 8'd0;
                month_out_reg <= 4'd0;
                day_out_reg   <= 5'd0;
            end
        end
    end

    assign out_valid       = valid_reg[NUM_STAGES-1];
    assign epoch_out       = epoch_out_reg;
    assign out_year_offset = year_out_reg;
    assign out_month       = month_out_reg;
    assign out_day         = day_out_reg;

    // Input is held off only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (act_reg[NUM_STAGES-1] == ACT_TO_DATE)) |-> (epoch_out == 32'd0))
        else $error("epoch field not cleared on a date result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (act_reg[NUM_STAGES-1] == ACT_TO_EPOCH))
        |-> (out_year_offset == 8'd0 && out_month == 4'd0 && out_day == 5'd0))
        else $error("date fields not cleared on an epoch result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (act_reg[NUM_STAGES-1] == ACT_TO_DATE))
        |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1))
        else $error("date result out of calendar range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
